// ===== hdl/rgl_pkg.sv =====
`timescale 1ns / 1ps
package rgl_pkg;

  localparam int FIELD_W = 32;

  // operation codes on the cmd port
  localparam logic [1:0] OPC_LCM   = 2'd0;
  localparam logic [1:0] OPC_GCD   = 2'd1;
  localparam logic [1:0] OPC_FLOOR = 2'd2;
  localparam logic [1:0] OPC_CEIL  = 2'd3;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV,
    OP_MUL,
    OP_GCD_INIT,
    OP_GCD_STEP,
    OP_MOVE,
    OP_INT_RES,
    OP_ZERO_RES,
    OP_OUT
  } op_t;

  typedef enum logic [3:0] {
    SRC_AN, SRC_AD, SRC_CN, SRC_CD, SRC_DEN, SRC_NUM, SRC_P, SRC_Q, SRC_G
  } src_t;

  typedef enum logic [3:0] {
    DST_AN, DST_AD, DST_CN, DST_CD, DST_DEN, DST_NUM, DST_P, DST_Q, DST_RN, DST_RD
  } dst_t;

  typedef struct packed {
    op_t  op;
    src_t srca;
    src_t srcb;
    dst_t dst;
    logic chk_y;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic gb_zero;
    logic ov;
    logic a_zero;
    logic b_zero;
  } dp_status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_WAIT, S_GCD, S_FL_DIV, S_FL_FIN,
    S_R1, S_R2, S_R3, S_R4, S_R5, S_R6, S_R7, S_R8, S_R9, S_R10,
    S_L1, S_L2, S_L3, S_L4, S_L5, S_L6, S_L7,
    S_G1, S_G2, S_M1, S_M2, S_M3, S_FINISH
  } state_t;

endpackage

// ===== hdl/rational_gcd_lcm_unit.sv =====
`timescale 1ns / 1ps
// Channel  Handshake           Payload
// -------  ------------------  ---------------------------------------
// in       in_valid/in_stall   cmd, x_num, x_den, y_num, y_den
// out      out_valid/out_stall res_num, res_den, overflow
//
// Floor and ceiling: one division on the one-bit-a-cycle restoring
// divider, DW = max(WIDTH, 32).
// LCM / GCD: data dependent, a series of divisions, Euclid steps and
// multiplications. One transaction is in flight at a time.
// Reset (rst, synchronous) clears the sequencer and output valid.
// A held result in the output register does not block the next input
// transaction; only the final write waits for out_stall to drop.
module rational_gcd_lcm_unit import rgl_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic [FIELD_W-1:0] x_num,
  input  logic [FIELD_W-1:0] x_den,
  input  logic [FIELD_W-1:0] y_num,
  input  logic [FIELD_W-1:0] y_den,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [FIELD_W-1:0] res_num,
  output logic [FIELD_W-1:0] res_den,
  output logic               overflow
);

  dp_cmd_t    ctl;
  dp_status_t st;

  // sequencer: walks reduce / lcm / gcd steps, calls Euclid as a subroutine
  rgl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl),
    .st        (st)
  );

  // register bank, shared divider and multiplier, output register
  rgl_datapath #(.WIDTH(WIDTH)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .st       (st),
    .x_num    (x_num),
    .x_den    (x_den),
    .y_num    (y_num),
    .y_den    (y_den),
    .res_num  (res_num),
    .res_den  (res_den),
    .overflow (overflow)
  );

  // a transaction taken in makes the unit busy next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("unit not busy after accepting a transaction");

  // overflowed results are flushed to 0/1
  a_ovf_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> res_num == '0 && res_den == FIELD_W'(1))
    else $error("overflow result not 0/1");

  // a delivered denominator is never zero
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> res_den != '0)
    else $error("zero denominator delivered");

  // a new result is only written once the previous one has been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(res_num) && $stable(res_den))
    else $error("held result overwritten");

endmodule

// ===== hdl/rgl_datapath.sv =====
`timescale 1ns / 1ps
module rgl_datapath import rgl_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            ctl,
  output dp_status_t         st,
  input  logic [FIELD_W-1:0] x_num,
  input  logic [FIELD_W-1:0] x_den,
  input  logic [FIELD_W-1:0] y_num,
  input  logic [FIELD_W-1:0] y_den,
  output logic [FIELD_W-1:0] res_num,
  output logic [FIELD_W-1:0] res_den,
  output logic               overflow
);

  localparam int DW = (WIDTH > FIELD_W) ? WIDTH : FIELD_W;
  localparam int CW = $clog2(DW);
  localparam logic [DW-1:0] LIM  = {DW{1'b1}} >> (DW - WIDTH);
  localparam logic [DW-1:0] FMAX = DW'({FIELD_W{1'b1}});
  localparam logic [DW-1:0] ONE  = DW'(1);

  logic [DW-1:0] an, ad, cn, cd, den, num, p, q, ga, gb, rn, rd;
  logic          ov;
  logic [DW-1:0] opa, opb;
  logic [DW-1:0] xn, xd, yn, yd;

  // divider
  logic          dbusy, dgcd;
  dst_t          ddst;
  logic [DW-1:0] dn, dd, drem;
  logic [CW-1:0] dcnt;
  logic [DW:0]   trial, trial_sub;
  logic          ge, ddone;
  logic [DW-1:0] drem_step, dn_step;

  // multiplier
  logic          mbusy;
  dst_t          mdst;
  logic [DW:0]   ma, msum, ma_sh;
  logic [DW-1:0] mb, mb_sh, acc;
  logic          mlast, m_ovf, mdone;

  logic          wr_en;
  dst_t          wr_dst;
  logic [DW-1:0] wr_val;
  logic          fin_ov;

  assign xn = DW'(x_num);
  assign xd = (x_den == '0) ? ONE : DW'(x_den);
  assign yn = DW'(y_num);
  assign yd = (y_den == '0) ? ONE : DW'(y_den);

  function automatic logic [DW-1:0] pick(src_t s, logic [DW-1:0] v_an, logic [DW-1:0] v_ad,
                                         logic [DW-1:0] v_cn, logic [DW-1:0] v_cd,
                                         logic [DW-1:0] v_den, logic [DW-1:0] v_num,
                                         logic [DW-1:0] v_p, logic [DW-1:0] v_q,
                                         logic [DW-1:0] v_g);
    logic [DW-1:0] r;
    unique case (s)
      SRC_AN:  r = v_an;
      SRC_AD:  r = v_ad;
      SRC_CN:  r = v_cn;
      SRC_CD:  r = v_cd;
      SRC_DEN: r = v_den;
      SRC_NUM: r = v_num;
      SRC_P:   r = v_p;
      SRC_Q:   r = v_q;
      SRC_G:   r = v_g;
      default: r = '0;
    endcase
    return r;
  endfunction

  assign opa = pick(ctl.srca, an, ad, cn, cd, den, num, p, q, ga);
  assign opb = pick(ctl.srcb, an, ad, cn, cd, den, num, p, q, ga);

  // restoring division, one quotient bit per cycle
  assign trial     = {drem, dn[DW-1]};
  assign ge        = trial >= {1'b0, dd};
  assign trial_sub = trial - {1'b0, dd};
  assign drem_step = ge ? trial_sub[DW-1:0] : trial[DW-1:0];
  assign dn_step   = {dn[DW-2:0], ge};
  assign ddone     = dbusy && (dcnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
    end else if (ctl.op == OP_DIV || ctl.op == OP_GCD_STEP) begin
      dbusy <= 1'b1;
      dgcd  <= (ctl.op == OP_GCD_STEP);
      ddst  <= ctl.dst;
      dn    <= (ctl.op == OP_GCD_STEP) ? ga : opa;
      dd    <= (ctl.op == OP_GCD_STEP) ? gb : opb;
      drem  <= '0;
      dcnt  <= CW'(DW - 1);
    end else if (dbusy) begin
      dn   <= dn_step;
      drem <= drem_step;
      dcnt <= dcnt - 1'b1;
      if (dcnt == '0) begin
        dbusy <= 1'b0;
      end
    end
  end

  // shift-add multiplier with overflow check against LIM
  assign msum  = {1'b0, acc} + (mb[0] ? ma : '0);
  assign mb_sh = mb >> 1;
  assign mlast = (mb_sh == '0);
  assign ma_sh = {ma[DW-1:0], 1'b0};
  assign m_ovf = (msum > {1'b0, LIM}) || (!mlast && (ma_sh > {1'b0, LIM}));
  assign mdone = mbusy && (m_ovf || mlast);

  always_ff @(posedge clk) begin
    if (rst) begin
      mbusy <= 1'b0;
    end else if (ctl.op == OP_MUL) begin
      mbusy <= 1'b1;
      mdst  <= ctl.dst;
      ma    <= {1'b0, opa};
      mb    <= opb;
      acc   <= '0;
    end else if (mbusy) begin
      acc <= msum[DW-1:0];
      mb  <= mb_sh;
      ma  <= ma_sh;
      if (mdone) begin
        mbusy <= 1'b0;
      end
    end
  end

  always_comb begin
    wr_en  = 1'b0;
    wr_dst = ctl.dst;
    wr_val = opa;
    priority if (ddone && !dgcd) begin
      wr_en  = 1'b1;
      wr_dst = ddst;
      wr_val = dn_step;
    end else if (mdone && !m_ovf) begin
      wr_en  = 1'b1;
      wr_dst = mdst;
      wr_val = msum[DW-1:0];
    end else if (ctl.op == OP_MOVE) begin
      wr_en = 1'b1;
    end
  end

  assign fin_ov = ov || (rn > FMAX) || (rd > FMAX) || (rn > LIM) || (rd > LIM);

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else begin
      if (ctl.op == OP_LOAD) begin
        an <= xn;
        ad <= xd;
        cn <= yn;
        cd <= yd;
        // integer results keep this denominator
        rd <= ONE;
        ov <= (xn > LIM) || (xd > LIM) || (ctl.chk_y && ((yn > LIM) || (yd > LIM)));
      end
      if (mdone && m_ovf) begin
        ov <= 1'b1;
      end
      if (wr_en) begin
        unique case (wr_dst)
          DST_AN:  an  <= wr_val;
          DST_AD:  ad  <= wr_val;
          DST_CN:  cn  <= wr_val;
          DST_CD:  cd  <= wr_val;
          DST_DEN: den <= wr_val;
          DST_NUM: num <= wr_val;
          DST_P:   p   <= wr_val;
          DST_Q:   q   <= wr_val;
          DST_RN:  rn  <= wr_val;
          DST_RD:  rd  <= wr_val;
          default: ;
        endcase
      end
      if (ddone && dgcd) begin
        ga <= gb;
        gb <= drem_step;
      end
      if (ctl.op == OP_GCD_INIT) begin
        ga <= opa;
        gb <= opb;
      end
      if (ctl.op == OP_INT_RES) begin
        rn <= rn + DW'(drem != '0);
        rd <= ONE;
      end
      if (ctl.op == OP_ZERO_RES) begin
        rn <= '0;
        rd <= ONE;
      end
      if (ctl.op == OP_OUT) begin
        res_num  <= fin_ov ? '0 : rn[FIELD_W-1:0];
        res_den  <= fin_ov ? FIELD_W'(1) : rd[FIELD_W-1:0];
        overflow <= fin_ov;
      end
    end
  end

  assign st.busy    = dbusy || mbusy;
  assign st.gb_zero = (gb == '0);
  assign st.ov      = ov;
  assign st.a_zero  = (opa == '0);
  assign st.b_zero  = (opb == '0);

endmodule

// ===== hdl/rgl_ctrl.sv =====
`timescale 1ns / 1ps
module rgl_ctrl import rgl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] cmd,
  output logic       out_valid,
  input  logic       out_stall,
  output dp_cmd_t    ctl,
  input  dp_status_t st
);

  state_t     state, state_next;
  state_t     ret, ret_next;
  state_t     gret, gret_next;
  logic [1:0] opc, opc_next;
  logic       out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= S_IDLE;
      gret      <= S_IDLE;
      opc       <= OPC_LCM;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ret       <= ret_next;
      gret      <= gret_next;
      opc       <= opc_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    ret_next   = ret;
    gret_next  = gret;
    opc_next   = opc;
    ctl        = '{op: OP_NONE, srca: SRC_AN, srcb: SRC_AN, dst: DST_AN, chk_y: 1'b0};
    out_valid_next = (out_valid && !out_stall) ? 1'b0 : out_valid;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.op    = OP_LOAD;
          ctl.chk_y = (cmd == OPC_LCM) || (cmd == OPC_GCD);
          opc_next  = cmd;
          state_next = ((cmd == OPC_LCM) || (cmd == OPC_GCD)) ? S_R1 : S_FL_DIV;
        end
      end
      S_WAIT: begin
        if (!st.busy) state_next = ret;
      end
      S_GCD: begin
        if (st.gb_zero) begin
          state_next = gret;
        end else begin
          ctl.op     = OP_GCD_STEP;
          ret_next   = S_GCD;
          state_next = S_WAIT;
        end
      end
      S_FL_DIV: begin
        ctl = '{op: OP_DIV, srca: SRC_AN, srcb: SRC_AD, dst: DST_RN, chk_y: 1'b0};
        ret_next = S_FL_FIN; state_next = S_WAIT;
      end
      S_FL_FIN: begin
        // ceiling rounds up on a nonzero remainder; floor keeps the quotient
        if (opc == OPC_CEIL) begin
          ctl.op = OP_INT_RES;
        end
        state_next = S_FINISH;
      end
      S_R1: begin
        ctl = '{op: OP_GCD_INIT, srca: SRC_AN, srcb: SRC_AD, dst: DST_AN, chk_y: 1'b0};
        gret_next = S_R2; state_next = S_GCD;
      end
      S_R2: begin
        ctl = '{op: OP_DIV, srca: SRC_AN, srcb: SRC_G, dst: DST_AN, chk_y: 1'b0};
        ret_next = S_R3; state_next = S_WAIT;
      end
      S_R3: begin
        ctl = '{op: OP_DIV, srca: SRC_AD, srcb: SRC_G, dst: DST_AD, chk_y: 1'b0};
        ret_next = S_R4; state_next = S_WAIT;
      end
      S_R4: begin
        ctl = '{op: OP_GCD_INIT, srca: SRC_CN, srcb: SRC_CD, dst: DST_AN, chk_y: 1'b0};
        gret_next = S_R5; state_next = S_GCD;
      end
      S_R5: begin
        ctl = '{op: OP_DIV, srca: SRC_CN, srcb: SRC_G, dst: DST_CN, chk_y: 1'b0};
        ret_next = S_R6; state_next = S_WAIT;
      end
      S_R6: begin
        ctl = '{op: OP_DIV, srca: SRC_CD, srcb: SRC_G, dst: DST_CD, chk_y: 1'b0};
        ret_next = S_R7; state_next = S_WAIT;
      end
      S_R7: begin
        ctl = '{op: OP_GCD_INIT, srca: SRC_AD, srcb: SRC_CD, dst: DST_AN, chk_y: 1'b0};
        gret_next = S_R8; state_next = S_GCD;
      end
      S_R8: begin
        ctl = '{op: OP_DIV, srca: SRC_AD, srcb: SRC_G, dst: DST_P, chk_y: 1'b0};
        ret_next = S_R9; state_next = S_WAIT;
      end
      S_R9: begin
        ctl = '{op: OP_MUL, srca: SRC_P, srcb: SRC_CD, dst: DST_DEN, chk_y: 1'b0};
        ret_next = S_R10; state_next = S_WAIT;
      end
      S_R10: begin
        if (st.ov) state_next = S_FINISH;
        else if (opc == OPC_LCM) state_next = S_L1;
        else state_next = S_G1;
      end
      S_L1: begin
        ctl = '{op: OP_DIV, srca: SRC_DEN, srcb: SRC_AD, dst: DST_P, chk_y: 1'b0};
        ret_next = S_L2; state_next = S_WAIT;
      end
      S_L2: begin
        ctl = '{op: OP_MUL, srca: SRC_AN, srcb: SRC_P, dst: DST_P, chk_y: 1'b0};
        ret_next = S_L3; state_next = S_WAIT;
      end
      S_L3: begin
        ctl = '{op: OP_DIV, srca: SRC_DEN, srcb: SRC_CD, dst: DST_Q, chk_y: 1'b0};
        ret_next = S_L4; state_next = S_WAIT;
      end
      S_L4: begin
        ctl = '{op: OP_MUL, srca: SRC_CN, srcb: SRC_Q, dst: DST_Q, chk_y: 1'b0};
        ret_next = S_L5; state_next = S_WAIT;
      end
      S_L5: begin
        ctl.srca = SRC_P;
        ctl.srcb = SRC_Q;
        if (st.ov) begin
          state_next = S_FINISH;
        end else if (st.a_zero || st.b_zero) begin
          ctl.op     = OP_ZERO_RES;
          state_next = S_FINISH;
        end else begin
          ctl.op     = OP_GCD_INIT;
          gret_next  = S_L6;
          state_next = S_GCD;
        end
      end
      S_L6: begin
        ctl = '{op: OP_DIV, srca: SRC_P, srcb: SRC_G, dst: DST_NUM, chk_y: 1'b0};
        ret_next = S_L7; state_next = S_WAIT;
      end
      S_L7: begin
        ctl = '{op: OP_MUL, srca: SRC_NUM, srcb: SRC_Q, dst: DST_NUM, chk_y: 1'b0};
        ret_next = S_M1; state_next = S_WAIT;
      end
      S_G1: begin
        ctl = '{op: OP_GCD_INIT, srca: SRC_AN, srcb: SRC_CN, dst: DST_AN, chk_y: 1'b0};
        gret_next = S_G2; state_next = S_GCD;
      end
      S_G2: begin
        ctl = '{op: OP_MOVE, srca: SRC_G, srcb: SRC_AN, dst: DST_NUM, chk_y: 1'b0};
        state_next = S_M1;
      end
      S_M1: begin
        ctl.srca = SRC_NUM;
        ctl.srcb = SRC_DEN;
        if (st.ov) begin
          state_next = S_FINISH;
        end else if (st.a_zero) begin
          ctl.op     = OP_ZERO_RES;
          state_next = S_FINISH;
        end else begin
          ctl.op     = OP_GCD_INIT;
          gret_next  = S_M2;
          state_next = S_GCD;
        end
      end
      S_M2: begin
        ctl = '{op: OP_DIV, srca: SRC_NUM, srcb: SRC_G, dst: DST_RN, chk_y: 1'b0};
        ret_next = S_M3; state_next = S_WAIT;
      end
      S_M3: begin
        ctl = '{op: OP_DIV, srca: SRC_DEN, srcb: SRC_G, dst: DST_RD, chk_y: 1'b0};
        ret_next = S_FINISH; state_next = S_WAIT;
      end
      S_FINISH: begin
        if (!out_valid || !out_stall) begin
          ctl.op         = OP_OUT;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
